// ===== hw/rtl/box_signed_distance_macros.svh =====
// ----------------------------------------------------------------------------
// box_signed_distance_macros: assertion macros
// clocked property checks, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef BOX_SIGNED_DISTANCE_MACROS_SVH
`define BOX_SIGNED_DISTANCE_MACROS_SVH

`ifndef SYNTH
// checked property, disabled while reset is high
`define BSD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bsd assertion failed");
// checked property, also checked during reset
`define BSD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bsd assertion failed");
`else
`define BSD_ASSERT(label, clk, rst, prop)
`define BSD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hw/rtl/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsd_pkg: box signed distance package
// widths, register indexes and pipeline types
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

  localparam int COORD_W  = 32;
  localparam int LEN_W    = 31;
  localparam int SQRT_N   = 32;   // result bits of the 64-bit square root
  localparam int REM_W    = 35;
  localparam int RAD_W    = 64;
  localparam int ADDR_W   = 5;

  localparam logic [COORD_W-1:0] SAT_MAX  = 32'h7fff_ffff;
  localparam logic [LEN_W-1:0]   LEN_RST  = 31'd65536;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_LENGTH   = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5
  } reg_idx_t;

  // side information that rides along the square root stages
  typedef struct packed {
    logic             in_box;
    logic [LEN_W-1:0] min_d;
    logic             sat;
  } side_t;

  // one square root stage
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [SQRT_N-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bsd_point_if.sv =====
// ----------------------------------------------------------------------------
// bsd_point_if: query point channel
// valid/ready channel carrying one 3d point
// ----------------------------------------------------------------------------
`default_nettype none

interface bsd_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [bsd_pkg::COORD_W-1:0]  point_x;
  logic signed [bsd_pkg::COORD_W-1:0]  point_y;
  logic signed [bsd_pkg::COORD_W-1:0]  point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bsd_dist_if.sv =====
// ----------------------------------------------------------------------------
// bsd_dist_if: distance result channel
// valid/ready channel carrying one signed distance
// ----------------------------------------------------------------------------
`default_nettype none

interface bsd_dist_if;
  logic                                valid;
  logic                                ready;
  logic signed [bsd_pkg::COORD_W-1:0]  signed_distance;

  modport source (output valid, output signed_distance, input ready);
  modport sink   (input valid, input signed_distance, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/box_signed_distance.sv =====
// ----------------------------------------------------------------------------
// box_signed_distance: signed distance from a point to an axis-aligned box
// q16.16 point in, q16.16 signed distance out, one transfer per cycle
// ----------------------------------------------------------------------------
// The block takes one Q16.16 point per cycle and returns its signed distance
// to the box held in the APB registers (center x/y/z, full length/width/
// height). Points strictly inside on every axis give minus the nearest face
// distance; all others give the Euclidean norm of the excess beyond the
// faces, rounded half up and saturated at 0x7fffffff. The datapath is a
// 38-stage pipeline: five stages of offset, magnitude, excess, square and
// sum, 32 stages of a restoring square root that settles one result bit per
// stage, and the output register. Throughput is one point per cycle unless
// the result stalls; the whole pipe moves on one enable, so a stalled result
// holds every stage. Registers must be written only while no transfer is in
// flight; the block does not enforce this.
`default_nettype none

`include "box_signed_distance_macros.svh"

module box_signed_distance (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bsd_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  bsd_point_if.sink                         point,
  bsd_dist_if.source                        result
);

  localparam int CW = bsd_pkg::COORD_W;
  localparam int LW = bsd_pkg::LEN_W;
  localparam int SN = bsd_pkg::SQRT_N;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CW-1:0] cen [3];
  logic [LW-1:0] len [3];
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        cen[i] <= '0;
        len[i] <= bsd_pkg::LEN_RST;
      end
    end else if (wr_en) begin
      unique case (paddr[4:2])
        bsd_pkg::REG_CENTER_X: cen[0] <= pwdata;
        bsd_pkg::REG_CENTER_Y: cen[1] <= pwdata;
        bsd_pkg::REG_CENTER_Z: cen[2] <= pwdata;
        bsd_pkg::REG_LENGTH:   len[0] <= pwdata[LW-1:0];
        bsd_pkg::REG_WIDTH:    len[1] <= pwdata[LW-1:0];
        bsd_pkg::REG_HEIGHT:   len[2] <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      bsd_pkg::REG_CENTER_X: prdata = cen[0];
      bsd_pkg::REG_CENTER_Y: prdata = cen[1];
      bsd_pkg::REG_CENTER_Z: prdata = cen[2];
      bsd_pkg::REG_LENGTH:   prdata = {1'b0, len[0]};
      bsd_pkg::REG_WIDTH:    prdata = {1'b0, len[1]};
      bsd_pkg::REG_HEIGHT:   prdata = {1'b0, len[2]};
      default:               prdata = '0;
    endcase
  end

  // whole pipe advances together; the output register is the last stage
  logic adv;
  assign adv         = !result.valid || result.ready;
  assign point.ready = adv;

  // --------------------------------------------------------------------------
  // stage 1: offset from center, p - c in 33 bits (r = 2 * offset)
  // --------------------------------------------------------------------------
  logic          v1;
  logic [CW:0]   off1 [3];
  logic [CW-1:0] pin  [3];

  assign pin[0] = point.point_x;
  assign pin[1] = point.point_y;
  assign pin[2] = point.point_z;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= point.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        off1[i] <= {pin[i][CW-1], pin[i]} - {cen[i][CW-1], cen[i]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: magnitude a = |2 * offset| in q.17 units
  // --------------------------------------------------------------------------
  logic          v2;
  logic [CW+1:0] a2 [3];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a2[i] <= {(off1[i][CW] ? (~off1[i] + 1'b1) : off1[i]), 1'b0};
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: excess beyond the face, or distance to it when within
  // --------------------------------------------------------------------------
  logic          v3;
  logic [CW-1:0] e3    [3];
  logic          ebig3 [3];   // excess of 2^32 or more
  logic [LW-1:0] d3    [3];
  logic          in3   [3];
  logic [CW+2:0] dif   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i] = {1'b0, a2[i]} - {4'b0, len[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        in3[i]   <= dif[i][CW+2];
        ebig3[i] <= !dif[i][CW+2] && (dif[i][CW+1:CW] != 2'b00);
        e3[i]    <= dif[i][CW+2] ? '0 : dif[i][CW-1:0];
        d3[i]    <= (~dif[i][LW-1:0]) + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: squared excesses, first minimum
  // --------------------------------------------------------------------------
  logic            v4;
  logic [2*CW-1:0] sq4 [3];
  logic            in4;
  logic            sat4;
  logic [LW-1:0]   m4;
  logic [LW-1:0]   d4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= e3[i] * e3[i];
      end
      in4  <= in3[0] && in3[1] && in3[2];
      sat4 <= ebig3[0] || ebig3[1] || ebig3[2];
      m4   <= (d3[1] < d3[0]) ? d3[1] : d3[0];
      d4   <= d3[2];
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: sum of squares, final minimum; feeds the square root
  // --------------------------------------------------------------------------
  logic [2*CW+1:0] sum4;
  assign sum4 = {2'b0, sq4[0]} + {2'b0, sq4[1]} + {2'b0, sq4[2]};

  logic           sv  [SN+1];
  bsd_pkg::side_t sb  [SN+1];
  bsd_pkg::sqrt_t sr  [SN+1];
  bsd_pkg::sqrt_t nxt [SN];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (adv) sv[0] <= v4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0].in_box <= in4;
      sb[0].min_d  <= (d4 < m4) ? d4 : m4;
      // a sum of 2^64 or more means a norm past the positive limit
      sb[0].sat    <= sat4 || (sum4[2*CW+1:2*CW] != 2'b00);
      sr[0].rem    <= '0;
      sr[0].root   <= '0;
      sr[0].rad    <= sum4[2*CW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // square root: one restoring step per stage, two radicand bits each
  // --------------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < SN; k++) begin
      logic [bsd_pkg::REM_W-1:0] r;
      logic [bsd_pkg::REM_W-1:0] t;
      r = {sr[k].rem[bsd_pkg::REM_W-3:0], sr[k].rad[bsd_pkg::RAD_W-1 -: 2]};
      t = {1'b0, sr[k].root, 2'b01};
      nxt[k].rad = {sr[k].rad[bsd_pkg::RAD_W-3:0], 2'b00};
      if (r >= t) begin
        nxt[k].rem  = r - t;
        nxt[k].root = {sr[k].root[SN-2:0], 1'b1};
      end else begin
        nxt[k].rem  = r;
        nxt[k].root = {sr[k].root[SN-2:0], 1'b0};
      end
    end
  end

  for (genvar k = 0; k < SN; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else if (adv) sv[k+1] <= sv[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sr[k+1] <= nxt[k];
        sb[k+1] <= sb[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register: round, saturate, pick inside or outside result
  // --------------------------------------------------------------------------
  logic [SN:0]   mag;
  logic [LW:0]   half_in;
  logic          sat_f;
  logic [CW-1:0] dist_f;
  logic          res_sat;
  logic          res_in;

  assign mag     = ({1'b0, sr[SN].root} + 1'b1) >> 1;
  assign half_in = ({1'b0, sb[SN].min_d} + 1'b1) >> 1;
  assign sat_f   = sb[SN].sat || mag[SN-1];

  // half_in is exactly as wide as the result
  always_comb begin
    if (sb[SN].in_box) dist_f = '0 - half_in;
    else if (sat_f)    dist_f = bsd_pkg::SAT_MAX;
    else               dist_f = mag[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (adv) result.valid <= sv[SN];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.signed_distance <= dist_f;
      res_sat                <= sat_f && !sb[SN].in_box;
      res_in                 <= sb[SN].in_box;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a point inside is at least one q.17 unit from every face: result below 0
  `BSD_ASSERT(a_inside_neg, clk, rst,
    result.valid && res_in |-> result.signed_distance[CW-1])
  // an outside result is never negative
  `BSD_ASSERT(a_outside_pos, clk, rst,
    result.valid && !res_in |-> !result.signed_distance[CW-1])
  // saturated outside results carry the positive limit
  `BSD_ASSERT(a_sat_max, clk, rst,
    result.valid && res_sat |-> result.signed_distance == bsd_pkg::SAT_MAX)
  // a stall freezes the pipe: the last square root stage holds
  `BSD_ASSERT(a_stall_hold, clk, rst,
    !adv |=> $stable(sv[SN]) && $stable(sr[SN].root))

endmodule

`default_nettype wire
